### design/stereo_flanger_defines.svh
// assertion macros for the stereo flanger
`ifndef STEREO_FLANGER_DEFINES_SVH
`define STEREO_FLANGER_DEFINES_SVH

`ifndef SYNTHESIS
`define SFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stereo_flanger: same-cycle check failed");
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stereo_flanger: next-cycle check failed");
`else
`define SFL_ASSERT_IMP(lbl, ante, cons)
`define SFL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/sfl_pkg.sv
package sfl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LFO_W      = 20;
  localparam int SWEEP_W    = 10;
  localparam int GAIN_W     = 16;
  localparam int HIST_LEN   = 1025;
  localparam int HIST_AW    = $clog2(HIST_LEN);
  localparam int FILL_W     = $clog2(HIST_LEN + 1);
  localparam int SINE_LEN   = 1024;
  localparam int PHASE_W    = $clog2(SINE_LEN);
  localparam int QUO_W      = PHASE_W + 1;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DLY_W      = 20;
  localparam int IP_W       = DLY_W - 8;
  localparam int X_W        = HIST_AW + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [16:0] COEF_A = 17'd102944;
  localparam logic [15:0] COEF_B = 16'd42334;
  localparam logic [12:0] COEF_C = 13'd5223;

  // fixed 250 sample offset in q12.8
  localparam logic signed [DLY_W-1:0] BASE_DELAY_Q8 = DLY_W'(250 * 256);
  localparam logic signed [X_W-1:0]   HIST_X        = X_W'(HIST_LEN);

  localparam logic [LFO_W-1:0]   LFO_PERIOD_RST = LFO_W'(44100);
  localparam logic [SWEEP_W-1:0] SWEEP_RST      = SWEEP_W'(100);
  localparam logic [GAIN_W-1:0]  GAIN_RST       = GAIN_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LFO_PERIOD = 2'd0,
    CFG_SWEEP      = 2'd1,
    CFG_WET_GAIN   = 2'd2
  } sfl_cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       last_in_block;
  } sfl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_out;
  } sfl_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } sfl_pair_t;

  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [HIST_AW-1:0] addr;
  } sfl_hist_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_SQ,
    ST_CU,
    ST_BSUB,
    ST_TU2,
    ST_ASUB,
    ST_TU,
    ST_SIN,
    ST_SWP,
    ST_DLY,
    ST_OFS,
    ST_WRAP0,
    ST_WRAP1,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_IML,
    ST_IMR,
    ST_GNL,
    ST_GNR,
    ST_RESR,
    ST_OUT
  } sfl_state_t;

endpackage

### design/sfl_hist.sv
module sfl_hist (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfl_pkg::sfl_hist_req_t req,
  input  sfl_pkg::sfl_pair_t    wdata,
  output sfl_pkg::sfl_pair_t    rdata
);
  import sfl_pkg::*;

  sfl_pair_t         mem [HIST_LEN];
  sfl_pair_t         q_r;
  logic              q_vld_r;
  logic [FILL_W-1:0] fill_r;

  // entries at or above the fill count were never written and read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (req.wr && (fill_r != FILL_W'(HIST_LEN))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= wdata;
    end
    if (req.rd) begin
      q_r     <= mem[req.addr];
      q_vld_r <= (FILL_W'(req.addr) < fill_r);
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

### design/sfl_div.sv
module sfl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sfl_pkg::LFO_W-1:0]   dividend,
  input  logic [sfl_pkg::LFO_W-1:0]   divisor,
  output logic                        done,
  output logic [sfl_pkg::QUO_W-1:0]   quotient
);
  import sfl_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [LFO_W-1:0] rem_r;
  logic [LFO_W-1:0] dvs_r;
  logic [QUO_W-1:0] bits_r;
  logic [QUO_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LFO_W:0]   r2;
  logic [LFO_W:0]   r2_sub;
  logic             ge;

  // restoring division of dividend * 2^PHASE_W, one quotient bit a cycle
  assign r2     = {rem_r, bits_r[QUO_W-1]};
  assign r2_sub = r2 - {1'b0, dvs_r};
  assign ge     = (r2 >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend[LFO_W-1:1]};
      bits_r <= {dividend[0], {PHASE_W{1'b0}}};
      dvs_r  <= divisor;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? r2_sub[LFO_W-1:0] : r2[LFO_W-1:0];
      bits_r <= {bits_r[QUO_W-2:0], 1'b0};
      q_r    <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### design/sfl_mul.sv
module sfl_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sfl_pkg::MUL_W-1:0]  a,
  input  logic signed [sfl_pkg::MUL_W-1:0]  b,
  output logic signed [sfl_pkg::PROD_W-1:0] p
);
  import sfl_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

### design/stereo_flanger.sv
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_data   (left_in, right_in, last_in_block)
// out       out  out_valid / out_stall  out_data  (left_out, right_out, last_out)
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each frame walks the sequencer states in turn before the next one is taken;
// the 11-step phase divider and the single 18x18 multiplier set how long it takes
// synchronous active-low reset; the delay history reads as zero until written
// a held output stalls only the final state; no new frame is taken while it waits
`include "stereo_flanger_defines.svh"

module stereo_flanger (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sfl_pkg::sfl_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sfl_pkg::sfl_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfl_pkg::*;

  // saturate a widened sum to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [18:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // control and configuration
  sfl_state_t           state_r, state_nxt;
  logic [HIST_AW-1:0]   wp_r;
  logic [LFO_W-1:0]     lfo_time_r;
  logic [LFO_W-1:0]     lfo_period_r;
  logic [SWEEP_W-1:0]   sweep_r;
  logic [GAIN_W-1:0]    gain_r;
  logic                 out_valid_r;
  sfl_out_t             out_data_r;

  // per-frame working registers
  sfl_in_t                    frame_r;
  logic [PHASE_W-1:0]         idx_r;
  logic [16:0]                u_r;
  logic [16:0]                u2_r;
  logic [MUL_W-1:0]           t_r;
  logic signed [SAMPLE_W-1:0] sin_r;
  logic signed [DLY_W-1:0]    d_r;
  logic signed [X_W-1:0]      x_r;
  sfl_pair_t                  prev_r;
  logic signed [SAMPLE_W:0]   diff_l_r, diff_r_r;
  logic signed [SAMPLE_W-1:0] wet_l_r, wet_r_r;
  logic signed [SAMPLE_W-1:0] res_l_r, res_r_r;

  // datapath wires
  logic [LFO_W-1:0]           period_eff;
  logic [LFO_W-1:0]           lfo_inc, lfo_upd;
  logic [HIST_AW-1:0]         wp_inc;
  logic [1:0]                 quad;
  logic [15:0]                u_frac;
  logic [16:0]                u_val;
  logic [MUL_W-1:0]           t_b, t_a;
  logic [18:0]                s_sum;
  logic [17:0]                s_rnd;
  logic [SAMPLE_W-1:0]        s_cap;
  logic signed [SAMPLE_W-1:0] sin_val;
  logic signed [DLY_W-1:0]    d_val;
  logic signed [X_W-1:0]      x_ofs, x_wrap;
  logic [HIST_AW-1:0]         tap_a, tap_b;
  logic signed [SAMPLE_W:0]   wet_l_val, wet_r_val;
  logic signed [18:0]         left_sum, right_sum;
  logic                       out_free, out_load;

  // shared units
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] p_r;
  logic                     div_start, div_done;
  logic [QUO_W-1:0]         div_q;
  sfl_hist_req_t            hist_req;
  sfl_pair_t                hist_q;

  sfl_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p_r)
  );

  // phase index = lfo_time * 1024 / period
  sfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lfo_upd),
    .divisor  (period_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  sfl_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .wdata ({frame_r.left_in, frame_r.right_in}),
    .rdata (hist_q)
  );

  // lfo time and write pointer
  assign period_eff = (lfo_period_r == '0) ? LFO_W'(1) : lfo_period_r;
  assign lfo_inc    = lfo_time_r + 1'b1;
  assign lfo_upd    = (lfo_inc > period_eff) ? '0 : lfo_inc;
  assign wp_inc     = (wp_r == HIST_AW'(HIST_LEN - 1)) ? '0 : wp_r + 1'b1;

  // quarter-wave polynomial: u in q16, mirrored on odd quadrants
  assign quad   = idx_r[PHASE_W-1:PHASE_W-2];
  assign u_frac = {idx_r[PHASE_W-3:0], 8'b0};
  assign u_val  = quad[0] ? (17'h10000 - {1'b0, u_frac}) : {1'b0, u_frac};
  assign t_b    = {2'b00, COEF_B} - {5'b0, p_r[28:16]};
  assign t_a    = {1'b0, COEF_A} - {2'b00, p_r[31:16]};

  // round q16 to q15, cap, then apply the sign half
  assign s_sum   = {1'b0, p_r[33:16]} + 19'd1;
  assign s_rnd   = s_sum[18:1];
  assign s_cap   = (s_rnd > 18'd32767) ? 16'h7fff : s_rnd[15:0];
  assign sin_val = quad[1] ? -$signed(s_cap) : $signed(s_cap);

  // q12.8 delay, floor of sweep * sin / 128
  assign d_val = BASE_DELAY_Q8 + $signed(p_r[26:7]);

  // tap offset from the advanced write pointer, then wrapped into the history
  assign x_ofs = $signed({{(X_W-HIST_AW){1'b0}}, wp_r})
               - $signed({{(X_W-IP_W){d_r[DLY_W-1]}}, d_r[DLY_W-1:8]});

  always_comb begin
    if (x_r < 0) begin
      x_wrap = x_r + HIST_X;
    end else if (x_r >= HIST_X) begin
      x_wrap = x_r - HIST_X;
    end else begin
      x_wrap = x_r;
    end
  end

  assign tap_b = x_r[HIST_AW-1:0];
  assign tap_a = (tap_b == '0) ? HIST_AW'(HIST_LEN - 1) : tap_b - 1'b1;

  // linear interpolation and wet mix
  assign wet_l_val = $signed({prev_r.left[SAMPLE_W-1], prev_r.left}) + $signed(p_r[24:8]);
  assign wet_r_val = $signed({prev_r.right[SAMPLE_W-1], prev_r.right}) + $signed(p_r[24:8]);
  assign left_sum  = $signed({{3{frame_r.left_in[SAMPLE_W-1]}}, frame_r.left_in})
                   + $signed({p_r[32], p_r[32:15]});
  assign right_sum = $signed({{3{frame_r.right_in[SAMPLE_W-1]}}, frame_r.right_in})
                   + $signed({p_r[32], p_r[32:15]});

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_CU;
      ST_CU:    state_nxt = ST_BSUB;
      ST_BSUB:  state_nxt = ST_TU2;
      ST_TU2:   state_nxt = ST_ASUB;
      ST_ASUB:  state_nxt = ST_TU;
      ST_TU:    state_nxt = ST_SIN;
      ST_SIN:   state_nxt = ST_SWP;
      ST_SWP:   state_nxt = ST_DLY;
      ST_DLY:   state_nxt = ST_OFS;
      ST_OFS:   state_nxt = ST_WRAP0;
      ST_WRAP0: state_nxt = ST_WRAP1;
      ST_WRAP1: state_nxt = ST_RDA;
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_IML;
      ST_IML:   state_nxt = ST_IMR;
      ST_IMR:   state_nxt = ST_GNL;
      ST_GNL:   state_nxt = ST_GNR;
      ST_GNR:   state_nxt = ST_RESR;
      ST_RESR:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: input stall, operand select for the shared multiplier, memory and divider, output load
  always_comb begin
    in_stall  = 1'b1;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    hist_req  = '{wr: 1'b0, rd: 1'b0, addr: wp_r};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_WRITE: begin
        hist_req  = '{wr: 1'b1, rd: 1'b0, addr: wp_r};
        div_start = 1'b1;
      end
      ST_SQ: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, u_val});
        mul_b  = $signed({1'b0, u_val});
      end
      ST_CU: begin
        mul_en = 1'b1;
        mul_a  = $signed({5'b0, COEF_C});
        mul_b  = $signed({1'b0, p_r[32:16]});
      end
      ST_TU2: begin
        mul_en = 1'b1;
        mul_a  = $signed(t_r);
        mul_b  = $signed({1'b0, u2_r});
      end
      ST_TU: begin
        mul_en = 1'b1;
        mul_a  = $signed(t_r);
        mul_b  = $signed({1'b0, u_r});
      end
      ST_SWP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-SWEEP_W){1'b0}}, sweep_r});
        mul_b  = $signed({{(MUL_W-SAMPLE_W){sin_r[SAMPLE_W-1]}}, sin_r});
      end
      ST_RDA: begin
        hist_req = '{wr: 1'b0, rd: 1'b1, addr: tap_a};
      end
      ST_RDB: begin
        hist_req = '{wr: 1'b0, rd: 1'b1, addr: tap_b};
      end
      ST_IML: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-8){1'b0}}, d_r[7:0]});
        mul_b  = $signed({diff_l_r[SAMPLE_W], diff_l_r});
      end
      ST_IMR: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-8){1'b0}}, d_r[7:0]});
        mul_b  = $signed({diff_r_r[SAMPLE_W], diff_r_r});
      end
      ST_GNL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-SAMPLE_W){wet_l_r[SAMPLE_W-1]}}, wet_l_r});
        mul_b  = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_r});
      end
      ST_GNR: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-SAMPLE_W){wet_r_r[SAMPLE_W-1]}}, wet_r_r});
        mul_b  = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_r});
      end
      ST_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      lfo_time_r   <= '0;
      lfo_period_r <= LFO_PERIOD_RST;
      sweep_r      <= SWEEP_RST;
      gain_r       <= GAIN_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WRITE) begin
        wp_r       <= wp_inc;
        lfo_time_r <= lfo_upd;
      end
      // unlisted register index is dropped
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LFO_PERIOD: lfo_period_r <= cfg_data[LFO_W-1:0];
          CFG_SWEEP:      sweep_r      <= cfg_data[SWEEP_W-1:0];
          CFG_WET_GAIN:   gain_r       <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, each loaded in the state or states that produce it
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE:  if (in_valid) frame_r <= in_data;
      ST_DIV:   if (div_done) idx_r <= div_q[PHASE_W-1:0];
      ST_SQ:    u_r <= u_val;
      ST_CU:    u2_r <= p_r[32:16];
      ST_BSUB:  t_r <= t_b;
      ST_ASUB:  t_r <= t_a;
      ST_SIN:   sin_r <= sin_val;
      ST_DLY:   d_r <= d_val;
      ST_OFS:   x_r <= x_ofs;
      ST_WRAP0: x_r <= x_wrap;
      ST_WRAP1: x_r <= x_wrap;
      ST_RDB:   prev_r <= hist_q;
      ST_DIFF: begin
        diff_l_r <= $signed({hist_q.left[SAMPLE_W-1], hist_q.left})
                  - $signed({prev_r.left[SAMPLE_W-1], prev_r.left});
        diff_r_r <= $signed({hist_q.right[SAMPLE_W-1], hist_q.right})
                  - $signed({prev_r.right[SAMPLE_W-1], prev_r.right});
      end
      ST_IMR:   wet_l_r <= wet_l_val[SAMPLE_W-1:0];
      ST_GNL:   wet_r_r <= wet_r_val[SAMPLE_W-1:0];
      ST_GNR:   res_l_r <= sat_sample(left_sum);
      ST_RESR:  res_r_r <= sat_sample(right_sum);
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= '{left_out: res_l_r, right_out: res_r_r,
                      last_out: frame_r.last_in_block};
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an input transfer always starts the history write next
  `SFL_ASSERT_NEXT(a_accept_write, in_valid && !in_stall, state_r == ST_WRITE)
  // two wrap steps bring any tap offset into the history range
  `SFL_ASSERT_IMP(a_tap_in_range, state_r == ST_RDA, (x_r >= 0) && (x_r < HIST_X))
  // the divider only finishes while the sequencer waits for it
  `SFL_ASSERT_IMP(a_div_done_in_div, div_done, state_r == ST_DIV)
  // a finished frame is presented on the next cycle
  `SFL_ASSERT_NEXT(a_out_load, out_load, out_valid)

endmodule
